@@ rtl/led_bt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer package
// Shared types, codes and duty helpers for the LED breath timer controller.
// ----------------------------------------------------------------------------
package led_bt_pkg;

    // Request codes carried on the slave tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LIGHT = 2'd1;
    localparam logic [1:0] REQ_COLOR = 2'd2;

    localparam logic [9:0] LEVEL_MAX = 10'd1000;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_WHITE = 2'd1,
        MODE_COLOR = 2'd2
    } mode_t;

    // One result beat, ch1 in the lowest bits
    typedef struct packed {
        logic [9:0] ch3;
        logic [9:0] ch2;
        logic [9:0] ch1;
    } pwm_t;

    // Clamp a requested duty to the maximum level
    function automatic logic [9:0] clamp_level(input logic [9:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    // Breathing duty: (level>>5) * breath >> 2, saturated
    function automatic logic [9:0] breath_duty(input logic [9:0] level,
                                               input logic [7:0] breath);
        logic [12:0] prod;
        logic [10:0] duty;
        prod = 13'(level[9:5]) * 13'(breath);
        duty = prod[12:2];
        return (duty > 11'(LEVEL_MAX)) ? LEVEL_MAX : duty[9:0];
    endfunction

endpackage

@@ rtl/led_bt_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer state core
// Holds the controller state and the low-power register, applies one
// accepted request per cycle and forms the PWM result of a tick.
// ----------------------------------------------------------------------------
module led_bt_core #(
    parameter int TICKS_PER_SECOND = 51,
    parameter int BREATH_PEAK      = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             fire,
    input  logic [1:0]       req_type,
    input  logic [9:0]       white_level_in,
    input  logic [15:0]      delay_in,
    input  logic [9:0]       red_in,
    input  logic [9:0]       green_in,
    input  logic [9:0]       blue_in,
    input  logic             breath_in,
    output logic             res_valid,
    output led_bt_pkg::pwm_t res
);
    import led_bt_pkg::*;

    localparam int PH_W = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TICKS_PER_SECOND - 1);
    localparam logic [PH_W-1:0] PH_MID  = PH_W'((TICKS_PER_SECOND - 1) / 2);
    localparam logic [7:0]      PEAK    = 8'(BREATH_PEAK);

    logic            low_power_reg;
    mode_t           mode_reg, mode_next;
    logic [7:0]      breath_reg, breath_next;
    logic            falling_reg, falling_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic [9:0]      white_reg, white_next;
    logic [15:0]     secs_reg, secs_next;
    logic            timer_reg, timer_next;
    logic [9:0]      red_reg, red_next;
    logic [9:0]      green_reg, green_next;
    logic [9:0]      blue_reg, blue_next;
    logic            bon_reg, bon_next;

    logic [7:0]      breath_step;
    logic [9:0]      white_clamped;

    // Request decode and tick update
    always_comb
    begin
        mode_next     = mode_reg;
        breath_next   = breath_reg;
        falling_next  = falling_reg;
        phase_next    = phase_reg;
        white_next    = white_reg;
        secs_next     = secs_reg;
        timer_next    = timer_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        bon_next      = bon_reg;
        res_valid     = 1'b0;
        res           = '0;
        white_clamped = clamp_level(white_level_in);
        breath_step   = falling_reg ? (breath_reg - 8'd1) : (breath_reg + 8'd1);

        if (fire)
        begin
            case (req_type)
                REQ_LIGHT:
                begin
                    white_next = white_clamped;
                    secs_next  = delay_in;
                    mode_next  = MODE_WHITE;
                    if (!timer_reg)
                    begin
                        timer_next = (delay_in != 16'd0) && (white_clamped != 10'd0);
                    end
                end
                REQ_COLOR:
                begin
                    red_next   = clamp_level(red_in);
                    green_next = clamp_level(green_in);
                    blue_next  = clamp_level(blue_in);
                    bon_next   = breath_in;
                    mode_next  = MODE_COLOR;
                end
                REQ_TICK:
                begin
                    // triangle counter, flips at either end
                    breath_next = breath_step;
                    if (!falling_reg)
                    begin
                        falling_next = (breath_step == PEAK);
                    end
                    else
                    begin
                        falling_next = (breath_step != 8'd0);
                    end
                    phase_next = (phase_reg >= PH_LAST) ? '0 : (phase_reg + 1'b1);

                    if (low_power_reg)
                    begin
                        res_valid = 1'b1;
                        res.ch3   = {6'd0, breath_step[7:4]};
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_WHITE:
                            begin
                                // countdown once per second at mid phase
                                if (timer_reg && (phase_next == PH_MID))
                                begin
                                    if (secs_reg <= 16'd1)
                                    begin
                                        timer_next = 1'b0;
                                        secs_next  = '0;
                                        white_next = '0;
                                    end
                                    else
                                    begin
                                        secs_next = secs_reg - 16'd1;
                                    end
                                end
                                breath_next  = '0;
                                falling_next = 1'b0;
                                res_valid    = 1'b1;
                                res.ch1      = white_next;
                                res.ch2      = white_next;
                                res.ch3      = white_next;
                            end
                            MODE_COLOR:
                            begin
                                res_valid = 1'b1;
                                if (bon_reg)
                                begin
                                    res.ch1 = breath_duty(blue_reg, breath_step);
                                    res.ch2 = breath_duty(green_reg, breath_step);
                                    res.ch3 = breath_duty(red_reg, breath_step);
                                end
                                else
                                begin
                                    breath_next  = '0;
                                    falling_next = 1'b0;
                                    res.ch1      = blue_reg;
                                    res.ch2      = green_reg;
                                    res.ch3      = red_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_power_reg <= 1'b0;
            mode_reg      <= MODE_NONE;
            breath_reg    <= '0;
            falling_reg   <= 1'b0;
            phase_reg     <= '0;
            white_reg     <= '0;
            secs_reg      <= '0;
            timer_reg     <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            bon_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                low_power_reg <= cfg_wr_data;
            end
            mode_reg    <= mode_next;
            breath_reg  <= breath_next;
            falling_reg <= falling_next;
            phase_reg   <= phase_next;
            white_reg   <= white_next;
            secs_reg    <= secs_next;
            timer_reg   <= timer_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            bon_reg     <= bon_next;
        end
    end

endmodule

@@ rtl/led_bt_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer result buffer
// Output register plus one skid entry, so a new beat can be taken while
// the current result waits on the master side.
// ----------------------------------------------------------------------------
module led_bt_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  led_bt_pkg::pwm_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output led_bt_pkg::pwm_t out_data
);
    import led_bt_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    pwm_t out_reg, skid_reg;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Occupancy control
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= in_data;
            end
            else
            begin
                skid_reg <= in_data;
            end
        end
    end

endmodule

@@ rtl/led_breath_timer_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer controller
// Tick-driven white/RGB LED duty controller with breathing and auto-off.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while s_tready is high. A tick beat
// (tuser 0) produces one registered PWM result beat on the master side,
// unless no mode is selected and low power is off; set-light (tuser 1) and
// set-color (tuser 2) beats update state and produce nothing. The whole
// update is combinational logic between the state registers and a result
// register backed by a skid entry, so s_tready stays high as long as at
// most one result is waiting. low_power is written through cfg_wr_en/cfg_wr_data between requests.
module led_breath_timer_controller_core #(
    parameter int TICKS_PER_SECOND = 51,
    parameter int BREATH_PEAK      = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // low_power
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] white_level_in, [25:10] delay_in, [35:26] red_in,
    // [45:36] green_in, [55:46] blue_in, [56] breath_in, [63:57] zero
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,        // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] pwm_ch1, [19:10] pwm_ch2, [29:20] pwm_ch3, [31:30] zero
    output logic [31:0] m_tdata
);
    import led_bt_pkg::*;

    logic fire;
    logic res_valid;
    pwm_t res;
    pwm_t out_data;

    assign fire = s_tvalid && s_tready;

    led_bt_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .BREATH_PEAK(BREATH_PEAK)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fire          (fire),
        .req_type      (s_tuser),
        .white_level_in(s_tdata[9:0]),
        .delay_in      (s_tdata[25:10]),
        .red_in        (s_tdata[35:26]),
        .green_in      (s_tdata[45:36]),
        .blue_in       (s_tdata[55:46]),
        .breath_in     (s_tdata[56]),
        .res_valid     (res_valid),
        .res           (res)
    );

    led_bt_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_data  (res),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    assign m_tdata = {2'b00, out_data.ch3, out_data.ch2, out_data.ch1};

endmodule

@@ rtl/led_bt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer port checker
// Port-level assertions for the controller, bound to the top level.
// ----------------------------------------------------------------------------
module led_bt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import led_bt_pkg::*;

    // Result register is empty the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Duties never exceed full scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:0] <= LEVEL_MAX) && (m_tdata[19:10] <= LEVEL_MAX)
                     && (m_tdata[29:20] <= LEVEL_MAX))
        else $error("duty above full scale");

    // A non-tick beat into an empty output produces no result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != REQ_TICK) && !m_tvalid |=> !m_tvalid)
        else $error("result produced by a set request");

endmodule

bind led_breath_timer_controller_core led_bt_checker u_led_bt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

@@ bench/led_breath_timer_controller_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breath timer controller testbench
// Streams tick, set-light, set-color and unused request beats into the core
// under several back-pressure profiles and low_power settings. A local model
// of the controller predicts each PWM result beat. The monitor compares every
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module led_breath_timer_controller_core_tb;
    import led_bt_pkg::*;

    localparam int TICKS        = 51;
    localparam int PEAK         = 128;
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] data;
    } req_beat_t;

    // DUT ports
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;

    // Stimulus control
    req_beat_t   req_q[$];
    req_beat_t   drv_beat;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold_on = 1'b0;
    event        hold_go;

    // Predicted PWM beats and error tally
    pwm_t        pwm_expected[$];
    pwm_t        pwm_got;
    pwm_t        pwm_exp;
    pwm_t        pwm_calc;
    int unsigned err_count = 0;

    // Model state of the controller
    mode_t       cur_mode    = MODE_NONE;
    logic [7:0]  breath_lvl  = '0;
    logic        breath_down = 1'b0;
    logic [5:0]  phase_cnt   = '0;
    logic [9:0]  white_duty  = '0;
    logic [15:0] secs_left   = '0;
    logic        timer_armed = 1'b0;
    logic [9:0]  red_duty    = '0;
    logic [9:0]  green_duty  = '0;
    logic [9:0]  blue_duty   = '0;
    logic        breath_en   = 1'b0;
    logic        lp_mode     = 1'b0;

    led_breath_timer_controller_core #(
        .TICKS_PER_SECOND(TICKS),
        .BREATH_PEAK     (PEAK)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    function automatic logic [9:0] sat_level(input logic [9:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    function automatic logic [9:0] breath_scale(input logic [9:0] lvl);
        int unsigned duty;
        duty = lvl[9:5];
        duty = (duty * breath_lvl) >> 2;
        return (duty > LEVEL_MAX) ? LEVEL_MAX : duty[9:0];
    endfunction

    // Apply one request beat; returns 1 when a PWM beat is due
    function automatic bit step_led(input logic [1:0] req, input logic [63:0] d,
                                    output pwm_t r);
        r = '0;
        if (req == REQ_LIGHT)
        begin
            white_duty = sat_level(d[9:0]);
            secs_left  = d[25:10];
            cur_mode   = MODE_WHITE;
            if (!timer_armed)
                timer_armed = (secs_left != 0) && (white_duty != 0);
            return 1'b0;
        end
        if (req == REQ_COLOR)
        begin
            red_duty   = sat_level(d[35:26]);
            green_duty = sat_level(d[45:36]);
            blue_duty  = sat_level(d[55:46]);
            breath_en  = d[56];
            cur_mode   = MODE_COLOR;
            return 1'b0;
        end
        if (req != REQ_TICK)
            return 1'b0;

        // triangle breath counter
        if (!breath_down)
        begin
            breath_lvl = breath_lvl + 8'd1;
            if (breath_lvl == 8'(PEAK))
                breath_down = 1'b1;
        end
        else
        begin
            breath_lvl = breath_lvl - 8'd1;
            if (breath_lvl == 8'd0)
                breath_down = 1'b0;
        end

        // phase within one second
        if (phase_cnt >= 6'(TICKS - 1))
            phase_cnt = '0;
        else
            phase_cnt = phase_cnt + 6'd1;

        if (lp_mode)
        begin
            r.ch3 = 10'(breath_lvl >> 4);
            return 1'b1;
        end

        if (cur_mode == MODE_WHITE)
        begin
            // countdown steps once per second at mid phase
            if (timer_armed && phase_cnt == 6'((TICKS - 1) / 2))
            begin
                if (secs_left <= 16'd1)
                begin
                    timer_armed = 1'b0;
                    secs_left   = '0;
                    white_duty  = '0;
                end
                else
                begin
                    secs_left = secs_left - 16'd1;
                end
            end
            breath_lvl  = '0;
            breath_down = 1'b0;
            r.ch1 = white_duty;
            r.ch2 = white_duty;
            r.ch3 = white_duty;
            return 1'b1;
        end

        if (cur_mode == MODE_COLOR)
        begin
            if (breath_en)
            begin
                r.ch1 = breath_scale(blue_duty);
                r.ch2 = breath_scale(green_duty);
                r.ch3 = breath_scale(red_duty);
            end
            else
            begin
                breath_lvl  = '0;
                breath_down = 1'b0;
                r.ch1 = blue_duty;
                r.ch2 = green_duty;
                r.ch3 = red_duty;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one beat in flight, held until accepted
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drv_beat = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_beat.data;
                s_tuser  <= drv_beat.req;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(hold_go);
            rx_hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Predict on accepted requests, check each result beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                lp_mode = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                if (step_led(s_tuser, s_tdata, pwm_calc))
                    pwm_expected.push_back(pwm_calc);
            end
            if (m_tvalid && m_tready)
            begin
                pwm_got = m_tdata[29:0];
                if (pwm_expected.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected pwm beat, expected none, got ch1 %0d ch2 %0d ch3 %0d",
                             $time, pwm_got.ch1, pwm_got.ch2, pwm_got.ch3);
                end
                else
                begin
                    pwm_exp = pwm_expected.pop_front();
                    if (pwm_got.ch1 != pwm_exp.ch1)
                    begin
                        err_count++;
                        $display("%0t: pwm_ch1 expected %0d got %0d",
                                 $time, pwm_exp.ch1, pwm_got.ch1);
                    end
                    if (pwm_got.ch2 != pwm_exp.ch2)
                    begin
                        err_count++;
                        $display("%0t: pwm_ch2 expected %0d got %0d",
                                 $time, pwm_exp.ch2, pwm_got.ch2);
                    end
                    if (pwm_got.ch3 != pwm_exp.ch3)
                    begin
                        err_count++;
                        $display("%0t: pwm_ch3 expected %0d got %0d",
                                 $time, pwm_exp.ch3, pwm_got.ch3);
                    end
                    if (m_tdata[31:30] != 2'b00)
                    begin
                        err_count++;
                        $display("%0t: tdata pad expected 0 got %0d", $time, m_tdata[31:30]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [9:0] rnd_level();
        case ($urandom_range(0, 6))
            0: return 10'd0;
            1: return 10'd1023;
            2: return LEVEL_MAX;
            3: return 10'($urandom_range(995, 1005));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic push_raw(input logic [1:0] req, input logic [63:0] d);
        req_q.push_back('{req: req, data: d});
    endtask

    task automatic push_tick();
        push_raw(REQ_TICK, {7'd0, 25'($urandom), 32'($urandom)});
    endtask

    task automatic push_light(input logic [9:0] w, input logic [15:0] dly);
        push_raw(REQ_LIGHT, {7'd0, 31'($urandom), dly, w});
    endtask

    task automatic push_color(input logic [9:0] r, input logic [9:0] g,
                              input logic [9:0] b, input logic br);
        push_raw(REQ_COLOR, {7'd0, br, b, g, r, 16'($urandom), 10'($urandom)});
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_tick();
    endtask

    // Mostly a set request followed by a run of ticks; some noise
    task automatic push_random_seq(output int added);
        int n;
        logic [15:0] dly;
        added = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                dly = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom);
                push_light(rnd_level(), dly);
                n = $urandom_range(1, 160);
                push_ticks(n);
                added = n + 1;
            end
            4, 5, 6:
            begin
                push_color(rnd_level(), rnd_level(), rnd_level(),
                           $urandom_range(0, 3) != 0);
                n = $urandom_range(1, 280);
                push_ticks(n);
                added = n + 1;
            end
            7:
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    push_raw(2'($urandom_range(0, 3)), {7'd0, 25'($urandom), 32'($urandom)});
                added = n;
            end
            8:
            begin
                // back-to-back set requests, no ticks in between
                push_color(rnd_level(), rnd_level(), rnd_level(), 1'($urandom));
                push_light(rnd_level(), 16'($urandom));
                added = 2;
            end
            default:
            begin
                n = $urandom_range(1, 40);
                push_ticks(n);
                added = n;
            end
        endcase
    endtask

    task automatic push_random(input int n_items);
        int total;
        int added;
        total = 0;
        @(negedge clk);
        while (total < n_items)
        begin
            push_random_seq(added);
            total += added;
        end
    endtask

    // Wait until no request is pending and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_q.size() != 0 || s_tvalid || pwm_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_low_power(input logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_low_power(1'b0);
        set_idling(0, 0);

        // Directed: no mode, unused code, clamps, re-arm, zero level/delay
        @(negedge clk);
        push_tick();
        push_raw(REQ_UNUSED, {7'd0, {57{1'b1}}});
        push_color(10'd1023, 10'd1023, 10'd1023, 1'b1);
        push_ticks(3);
        push_color(LEVEL_MAX, 10'd1001, 10'd0, 1'b0);
        push_tick();
        push_light(10'd1023, 16'hFFFF);
        push_tick();
        push_light(10'd0, 16'd1);
        push_tick();
        push_light(10'd1001, 16'd0);
        push_tick();
        push_light(10'd0, 16'd0);
        push_tick();
        push_color(10'd0, 10'd1023, 10'd999, 1'b1);
        push_ticks(2);
        wait_drained();

        // Random, no idling
        push_random(250);
        wait_drained();

        // Low power, sender idling
        write_low_power(1'b1);
        set_idling(69, 0);
        push_random(200);
        wait_drained();

        // Receiver stalling
        write_low_power(1'b0);
        set_idling(0, 69);
        push_random(250);
        wait_drained();

        // Both sides idling, low power
        write_low_power(1'b1);
        set_idling(28, 28);
        push_random(150);
        wait_drained();

        // Fill the core while the sink holds off
        write_low_power(1'b0);
        set_idling(0, 0);
        push_color(10'($urandom), 10'($urandom), 10'($urandom), 1'b1);
        push_ticks(60);
        -> hold_go;
        wait_drained();

        // Sender pauses here until all results are in, then resumes
        set_idling(28, 28);
        push_random(200);
        wait_drained();

        err_count += pwm_expected.size();
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ led_breath_timer_controller_core.f @@
rtl/led_bt_pkg.sv
rtl/led_bt_core.sv
rtl/led_bt_outbuf.sv
rtl/led_breath_timer_controller_core.sv
rtl/led_bt_checker.sv
bench/led_breath_timer_controller_core_tb.sv
